[sv/sh64_pkg.sv]
// Shared types and constants for the 64-bit string hash.
package sh64_pkg;

  localparam logic [63:0] PRIME_A = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PRIME_B = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PRIME_C = 64'h165667B19E3779F9;

  // Constant multiplicand selector for the shared multiplier
  typedef enum logic [1:0] {
    MC_PA,
    MC_PB,
    MC_PC
  } mul_const_t;

  // Multiply request from the sequencer
  typedef struct packed {
    logic        start;
    mul_const_t  csel;
    logic [63:0] operand;
  } mul_req_t;

  // Multiply response back to the sequencer
  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

endpackage

[sv/sh64_if.sv]
// Valid/ready channel interfaces for message words and finished hashes.
interface sh64_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] word;
  logic [3:0]  valid_bytes;
  logic        last;
  logic [31:0] message_length;

  modport source (output valid, word, valid_bytes, last, message_length, input ready);
  modport sink   (input valid, word, valid_bytes, last, message_length, output ready);
endinterface

interface sh64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

[sv/sh64_mul.sv]
// Iterative 64x64 (low half) multiplier by a hash prime, one 32x32 product per cycle.
module sh64_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  sh64_pkg::mul_req_t req,
  output sh64_pkg::mul_rsp_t rsp
);

  logic [63:0] a_r;
  logic [63:0] c_r;
  logic [63:0] p_r;
  logic [63:0] acc_r;
  logic [1:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] a_part;
  logic [31:0] b_part;
  logic [63:0] prod;
  logic [63:0] cval;

  // Pick the constant multiplicand
  always_comb begin
    case (req.csel)
      sh64_pkg::MC_PA: cval = sh64_pkg::PRIME_A;
      sh64_pkg::MC_PB: cval = sh64_pkg::PRIME_B;
      sh64_pkg::MC_PC: cval = sh64_pkg::PRIME_C;
      default:         cval = sh64_pkg::PRIME_A;
    endcase
  end

  // Partial products: lo*lo, hi*lo, lo*hi (hi*hi falls outside the low half)
  assign a_part = (cnt_r == 2'd1) ? a_r[63:32] : a_r[31:0];
  assign b_part = (cnt_r == 2'd2) ? c_r[63:32] : c_r[31:0];
  assign prod   = a_part * b_part;

  // Control: start, step, finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: latch operands, register each partial product, accumulate
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      a_r <= req.operand;
      c_r <= cval;
    end
    if (busy_r) begin
      p_r <= prod;
      case (cnt_r)
        2'd1:    acc_r <= p_r;
        2'd2:    acc_r <= acc_r + {p_r[31:0], 32'd0};
        2'd3:    acc_r <= acc_r + {p_r[31:0], 32'd0};
        default: acc_r <= acc_r;
      endcase
    end
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

[sv/string_hash_64.sv]
// Top level: sequencer for the 64-bit string hash around one shared multiplier.
//
//  channel | dir | payload                                      | accept
//  in_ch   | in  | word, valid_bytes, last, message_length      | valid & ready
//  out_ch  | out | hash_value                                   | valid & ready
//
//  Each 64-bit multiply runs as 32x32 partial products in the shared multiplier
//  unit, which sets the pace: a full word takes the K1, K2 and HM multiplies,
//  a partial word K1 and K2, a message start adds SEED, the avalanche AV1 and AV2.
//  in_ch.ready is high only while the sequencer is idle.
//  A finished hash waits in the output register; the next item is taken meanwhile.
//  Reset (rst_n low, synchronous) returns to idle awaiting a first item.
module string_hash_64 #(
  parameter int LENGTH_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  sh64_in_if.sink         in_ch,
  sh64_out_if.source      out_ch
);

  localparam int LEN_W = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_MIX,
    ST_K1,
    ST_K2,
    ST_HM,
    ST_FIN,
    ST_AV1,
    ST_AV2,
    ST_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic [63:0] word_r, word_nxt;
  logic        nb8_r, nb8_nxt;
  logic        nbz_r, nbz_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;

  sh64_pkg::mul_req_t mreq;
  sh64_pkg::mul_rsp_t mrsp;

  logic        accept;
  logic [3:0]  nb_eff;
  logic [63:0] tail;
  logic [63:0] len64;
  logic [63:0] kx;
  logic [63:0] hx;
  logic [63:0] p;

  sh64_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign accept            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = out_hash_r;
  assign p                 = mrsp.product;

  // Clamp byte count and zero unused bytes
  always_comb begin
    nb_eff = in_ch.valid_bytes[3] ? 4'd8 : in_ch.valid_bytes;
    for (int i = 0; i < 8; i++) begin
      tail[8*i +: 8] = (4'(i) < nb_eff) ? in_ch.word[8*i +: 8] : 8'd0;
    end
  end

  assign len64 = 64'(in_ch.message_length[LEN_W-1:0]);
  assign kx    = hash_r ^ p;
  assign hx    = hash_r ^ {33'd0, hash_r[63:33]};

  // Next state and multiply issue
  always_comb begin
    state_nxt     = state_r;
    in_msg_nxt    = in_msg_r;
    hash_nxt      = hash_r;
    word_nxt      = word_r;
    nb8_nxt       = nb8_r;
    nbz_nxt       = nbz_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hash_nxt  = out_hash_r;
    mreq.start    = 1'b0;
    mreq.csel     = sh64_pkg::MC_PB;
    mreq.operand  = word_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          word_nxt = tail;
          nb8_nxt  = (nb_eff == 4'd8);
          nbz_nxt  = (nb_eff == 4'd0);
          last_nxt = in_ch.last;
          if (!in_msg_r) begin
            mreq.start   = 1'b1;
            mreq.csel    = sh64_pkg::MC_PB;
            mreq.operand = len64;
            state_nxt    = ST_SEED;
          end else begin
            state_nxt = ST_MIX;
          end
        end
      end
      ST_SEED: begin
        if (mrsp.done) begin
          hash_nxt   = sh64_pkg::PRIME_A + p;
          in_msg_nxt = 1'b1;
          state_nxt  = ST_MIX;
        end
      end
      ST_MIX: begin
        if (nbz_r) begin
          state_nxt = ST_FIN;
        end else begin
          mreq.start   = 1'b1;
          mreq.csel    = sh64_pkg::MC_PB;
          mreq.operand = word_r;
          state_nxt    = ST_K1;
        end
      end
      ST_K1: begin
        if (mrsp.done) begin
          mreq.start   = 1'b1;
          mreq.csel    = sh64_pkg::MC_PA;
          mreq.operand = {p[32:0], p[63:33]};
          state_nxt    = ST_K2;
        end
      end
      ST_K2: begin
        if (mrsp.done) begin
          hash_nxt = kx;
          if (nb8_r) begin
            mreq.start   = 1'b1;
            mreq.csel    = sh64_pkg::MC_PC;
            mreq.operand = {kx[36:0], kx[63:37]};
            state_nxt    = ST_HM;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_HM: begin
        if (mrsp.done) begin
          hash_nxt  = p;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else begin
          mreq.start   = 1'b1;
          mreq.csel    = sh64_pkg::MC_PB;
          mreq.operand = hx;
          state_nxt    = ST_AV1;
        end
      end
      ST_AV1: begin
        if (mrsp.done) begin
          mreq.start   = 1'b1;
          mreq.csel    = sh64_pkg::MC_PC;
          mreq.operand = p ^ {29'd0, p[63:29]};
          state_nxt    = ST_AV2;
        end
      end
      ST_AV2: begin
        if (mrsp.done) begin
          hash_nxt  = p;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_hash_nxt  = hash_r ^ {32'd0, hash_r[63:32]};
          out_valid_nxt = 1'b1;
          hash_nxt      = 64'd0;
          in_msg_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_msg_r    <= in_msg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hash_r     <= hash_nxt;
    word_r     <= word_nxt;
    nb8_r      <= nb8_nxt;
    nbz_r      <= nbz_nxt;
    last_r     <= last_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule

[sv/sh64_checker.sv]
// Port-level checks for the 64-bit string hash, bound to the top level.
module sh64_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_hash_value
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash_value))
    else $error("stalled hash dropped or changed");

  // Drop ready for the work that follows an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an accepted transaction");

  // Come out of reset idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // A new result never appears in the cycle right after an accepted transaction
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind string_hash_64 sh64_checker u_sh64_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_hash_value (out_ch.hash_value)
);
